// File: hw/rtl/rass_pkg.sv
package rass_pkg;

	// pending-range queue geometry
	localparam int unsigned QUEUE_DEPTH = 16;
	localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned QSUM_W = QCW + 1;
	localparam int unsigned ENTRY_W = 64;

	localparam logic [15:0] MAX_SEG_RESET = 16'd1024;

	typedef enum logic {
		REG_MAX_SEGMENT = 1'b0,
		REG_TOTAL_BYTES = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PICK,
		ST_SERVE,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic capture;
		logic check;
		logic read_head;
		logic serve_queue;
		logic serve_fresh;
		logic serve_idle;
		logic load_marker;
	} cmd_t;

	typedef struct packed {
		logic queue_empty;
		logic fresh_left;
		logic marker_pend;
	} sts_t;

endpackage

// File: hw/rtl/rass_ram.sv
module rass_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/rass_ctrl.sv
module rass_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output rass_pkg::cmd_t   cmd,
	input  rass_pkg::sts_t   sts
);

	rass_pkg::state_t state_q;
	rass_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rass_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rass_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = rass_pkg::ST_CHECK;
			end
			rass_pkg::ST_CHECK: state_nxt = rass_pkg::ST_PICK;
			rass_pkg::ST_PICK: begin
				if (!sts.queue_empty) state_nxt = rass_pkg::ST_SERVE;
				else state_nxt = rass_pkg::ST_SEND;
			end
			rass_pkg::ST_SERVE: state_nxt = rass_pkg::ST_SEND;
			rass_pkg::ST_SEND: begin
				if (!out_stall && !sts.marker_pend) state_nxt = rass_pkg::ST_IDLE;
			end
			default: state_nxt = rass_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			rass_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.capture = in_valid;
			end
			rass_pkg::ST_CHECK: cmd.check = 1'b1;
			rass_pkg::ST_PICK: begin
				if (!sts.queue_empty) cmd.read_head = 1'b1;
				else if (sts.fresh_left) cmd.serve_fresh = 1'b1;
				else cmd.serve_idle = 1'b1;
			end
			rass_pkg::ST_SERVE: cmd.serve_queue = 1'b1;
			rass_pkg::ST_SEND: begin
				out_valid = 1'b1;
				cmd.load_marker = !out_stall && sts.marker_pend;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> (state_q == rass_pkg::ST_IDLE))
		else $error("input taken outside idle");

	a_marker_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_marker |=> out_valid)
		else $error("end marker not presented after data word");

	a_serve_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.serve_queue |-> $past(cmd.read_head))
		else $error("queue served without head read");

endmodule

// File: hw/rtl/rass_dp.sv
module rass_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rass_pkg::cmd_t        cmd,
	output rass_pkg::sts_t        sts,
	input  logic                  cfg_write,
	input  logic                  cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic                  operation,
	input  logic [31:0]           range_start,
	input  logic [31:0]           range_end,
	output logic                  seg_valid,
	output logic [31:0]           seg_start,
	output logic [32:0]           seg_end,
	output logic [15:0]           seg_length,
	output logic                  is_end_marker,
	output logic                  request_dropped,
	output logic                  last_result
);

	logic [15:0] max_segment_q;
	logic [31:0] total_bytes_q;

	logic [rass_pkg::QAW-1:0] head_q;
	logic [rass_pkg::QCW-1:0] count_q;
	logic [31:0]              sent_q;
	logic                     marker_pend_q;

	logic        op_q;
	logic [31:0] rs_q;
	logic [31:0] re_q;
	logic        drop_q;

	logic [15:0] maxseg;
	logic        drop;
	logic        push;

	logic [rass_pkg::QSUM_W-1:0] tail_sum;
	logic [rass_pkg::QSUM_W-1:0] tail_wrap;
	logic [rass_pkg::QAW-1:0]    tail;
	logic [rass_pkg::QAW-1:0]    head_inc;

	logic                         ram_we;
	logic [rass_pkg::QAW-1:0]     ram_waddr;
	logic [rass_pkg::ENTRY_W-1:0] ram_wdata;
	logic [rass_pkg::ENTRY_W-1:0] ram_rdata;

	logic [31:0] q_start;
	logic [31:0] q_end;
	logic [32:0] q_diff;
	logic [32:0] q_span;
	logic        q_split;

	logic [31:0] remaining;
	logic        fresh_fin;
	logic [15:0] chunk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_segment_q <= rass_pkg::MAX_SEG_RESET;
			total_bytes_q <= '0;
		end else if (cfg_write) begin
			unique case (rass_pkg::reg_index_t'(cfg_index))
				rass_pkg::REG_MAX_SEGMENT: max_segment_q <= cfg_data[15:0];
				rass_pkg::REG_TOTAL_BYTES: total_bytes_q <= cfg_data;
			endcase
		end
	end

	// zero segment size counts as one byte
	assign maxseg = (max_segment_q == 16'd0) ? 16'd1 : max_segment_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= operation;
			rs_q <= range_start;
			re_q <= range_end;
		end
		if (cmd.check) begin
			drop_q <= drop;
		end
	end

	assign drop = op_q && ((re_q < rs_q) ||
		(count_q == rass_pkg::QCW'(rass_pkg::QUEUE_DEPTH)));
	assign push = cmd.check && op_q && !drop;

	assign tail_sum = rass_pkg::QSUM_W'(head_q) + rass_pkg::QSUM_W'(count_q);
	assign tail_wrap = (tail_sum >= rass_pkg::QSUM_W'(rass_pkg::QUEUE_DEPTH)) ?
		tail_sum - rass_pkg::QSUM_W'(rass_pkg::QUEUE_DEPTH) : tail_sum;
	assign tail = tail_wrap[rass_pkg::QAW-1:0];
	assign head_inc = (head_q == rass_pkg::QAW'(rass_pkg::QUEUE_DEPTH - 1)) ?
		'0 : head_q + rass_pkg::QAW'(1);

	// head entry as read out of the queue memory
	assign q_start = ram_rdata[63:32];
	assign q_end   = ram_rdata[31:0];
	assign q_diff  = {1'b0, q_end} - {1'b0, q_start};
	assign q_span  = q_diff + 33'd1;
	assign q_split = q_diff >= {17'd0, maxseg};

	assign remaining = total_bytes_q - sent_q;
	assign fresh_fin = remaining <= {16'd0, maxseg};
	assign chunk     = fresh_fin ? remaining[15:0] : maxseg;

	assign ram_we    = push || (cmd.serve_queue && q_split);
	assign ram_waddr = cmd.serve_queue ? head_q : tail;
	assign ram_wdata = cmd.serve_queue ? {q_start + 32'(maxseg), q_end} : {rs_q, re_q};

	rass_ram #(
		.WIDTH(rass_pkg::ENTRY_W),
		.DEPTH(rass_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			count_q       <= '0;
			sent_q        <= '0;
			marker_pend_q <= 1'b0;
		end else begin
			if (push) begin
				count_q <= count_q + rass_pkg::QCW'(1);
			end
			if (cmd.serve_queue && !q_split) begin
				head_q  <= head_inc;
				count_q <= count_q - rass_pkg::QCW'(1);
			end
			if (cmd.serve_fresh) begin
				sent_q        <= sent_q + 32'(chunk);
				marker_pend_q <= fresh_fin;
			end
			if (cmd.load_marker) begin
				marker_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.serve_queue) begin
			seg_valid     <= 1'b1;
			seg_start     <= q_start;
			seg_end       <= q_split ? ({1'b0, q_start} + {17'd0, maxseg} - 33'd1)
				: {1'b0, q_end};
			seg_length    <= q_split ? maxseg : q_span[15:0];
			is_end_marker <= 1'b0;
			last_result   <= 1'b1;
		end else if (cmd.serve_fresh) begin
			seg_valid     <= 1'b1;
			seg_start     <= sent_q;
			seg_end       <= {1'b0, sent_q} + {17'd0, chunk} - 33'd1;
			seg_length    <= chunk;
			is_end_marker <= 1'b0;
			last_result   <= !fresh_fin;
		end else if (cmd.serve_idle) begin
			seg_valid     <= 1'b0;
			seg_start     <= '0;
			seg_end       <= '0;
			seg_length    <= '0;
			is_end_marker <= 1'b0;
			last_result   <= 1'b1;
		end else if (cmd.load_marker) begin
			seg_valid     <= 1'b1;
			seg_start     <= total_bytes_q;
			seg_end       <= {1'b0, total_bytes_q} + 33'd1;
			seg_length    <= '0;
			is_end_marker <= 1'b1;
			last_result   <= 1'b1;
		end
	end

	assign request_dropped = drop_q;

	assign sts.queue_empty = (count_q == '0);
	assign sts.fresh_left  = sent_q < total_bytes_q;
	assign sts.marker_pend = marker_pend_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rass_pkg::QCW'(rass_pkg::QUEUE_DEPTH))
		else $error("pending queue count overflow");

	a_serve_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.serve_queue |-> !sts.queue_empty)
		else $error("served an empty queue");

	a_sent_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.serve_fresh |=> (sent_q <= total_bytes_q) && !$past(sts.marker_pend))
		else $error("fresh data overran file size");

endmodule

// File: hw/rtl/retransmit_aware_segment_scheduler_unit.sv
// Sender-side segment scheduler. Each input word is one send opportunity and may also carry an
// inclusive retransmission range (operation = 1), which is appended to a 16-entry FIFO held in a
// small RAM. Pending ranges go first, cut into pieces of at most max_segment bytes; otherwise the
// next fresh chunk of the file is sent, or a word with seg_valid low once the whole file is sent,
// and the final fresh chunk is followed by an end-marker word (start = total_bytes, end =
// total_bytes + 1, length 0). A request that finds the FIFO full or has range_end below range_start
// is dropped, and request_dropped is set on every result word of that item. The block handles one
// item at a time: in_stall is low only when it is idle. A queued range passes through an extra
// serve state for the registered read of the FIFO head; an end marker adds one more word. The next
// item is taken the cycle after the last result word is accepted. Configuration (max_segment at
// index 0, total_bytes at index 1) is written through cfg_write; the user must write it only while
// the block is idle, which the block itself does not enforce; max_segment of 0 acts as 1.
module retransmit_aware_segment_scheduler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [31:0] range_start,
	input  logic [31:0] range_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        seg_valid,
	output logic [31:0] seg_start,
	output logic [32:0] seg_end,
	output logic [15:0] seg_length,
	output logic        is_end_marker,
	output logic        request_dropped,
	output logic        last_result
);

	rass_pkg::cmd_t cmd;
	rass_pkg::sts_t sts;

	// sequencer: walks capture, queue check, pick, serve and send
	rass_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath: config registers, range FIFO, byte counters and result register
	rass_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.operation      (operation),
		.range_start    (range_start),
		.range_end      (range_end),
		.seg_valid      (seg_valid),
		.seg_start      (seg_start),
		.seg_end        (seg_end),
		.seg_length     (seg_length),
		.is_end_marker  (is_end_marker),
		.request_dropped(request_dropped),
		.last_result    (last_result)
	);

endmodule
